FILE: rtl/core/wsac_pkg.sv
// Shared constants and helpers for the weighted-sum ASCII checksum block.
// No dependencies; imported by every module of the block.
package wsac_pkg;

	localparam int MSG_BYTES  = 8;
	localparam int MSG_W      = 64;
	localparam int DC_W       = 5;
	localparam int SUM1_W     = 16;
	localparam int SUM2_W     = 14;
	localparam int CODE_W     = 24;
	localparam int HEX_DIGITS = MSG_W / 4;
	localparam int PAIRS      = 4;
	localparam int NIB_PAIRS  = HEX_DIGITS / 2;

	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam logic [7:0] ASCII_GAP  = 8'd7;
	localparam logic [3:0] DEC_MAX    = 4'h9;

	// Uppercase ASCII code of one hex digit.
	function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
		logic [7:0] gap;
		gap = (nib > DEC_MAX) ? ASCII_GAP : 8'd0;
		return ASCII_ZERO + {4'd0, nib} + gap;
	endfunction

	// Message byte i, or zero for bytes past the configured message size.
	function automatic logic [7:0] msg_byte(input logic [MSG_W-1:0] msg, input int i);
		logic [7:0] b;
		b = (i < MSG_BYTES) ? msg[8*i +: 8] : 8'd0;
		return b;
	endfunction

endpackage

FILE: rtl/core/wsac_sum.sv
// Weighted byte sums: constant-weight products and pair sums, then the two totals.
// Depends on wsac_pkg.
module wsac_sum import wsac_pkg::*; (
	input  logic              clk,
	input  logic [MSG_W-1:0]  message,
	output logic [SUM1_W-1:0] sum1_s2,
	output logic [SUM2_W-1:0] sum2_s2
);

	logic [SUM1_W-1:0] pair1_c [PAIRS];
	logic [SUM2_W-1:0] pair2_c [PAIRS];
	logic [SUM1_W-1:0] pair1_s1 [PAIRS];
	logic [SUM2_W-1:0] pair2_s1 [PAIRS];
	logic [SUM1_W-1:0] tot1_c;
	logic [SUM2_W-1:0] tot2_c;

	always_comb begin
		for (int k = 0; k < PAIRS; k++) begin
			pair1_c[k] = SUM1_W'({8'd0, msg_byte(message, 2*k)}     * SUM1_W'(2*k + 2))
			           + SUM1_W'({8'd0, msg_byte(message, 2*k + 1)} * SUM1_W'(2*k + 3));
			pair2_c[k] = SUM2_W'({6'd0, msg_byte(message, 2*k)}     * SUM2_W'(2*k + 1))
			           + SUM2_W'({6'd0, msg_byte(message, 2*k + 1)} * SUM2_W'(2*k + 2));
		end
	end

	always_ff @(posedge clk) begin
		pair1_s1 <= pair1_c;
		pair2_s1 <= pair2_c;
	end

	always_comb begin
		tot1_c = '0;
		tot2_c = '0;
		for (int k = 0; k < PAIRS; k++) begin
			tot1_c = tot1_c + pair1_s1[k];
			tot2_c = tot2_c + pair2_s1[k];
		end
	end

	// The first sum is subtracted from zero and wraps at 16 bits.
	always_ff @(posedge clk) begin
		sum1_s2 <= SUM1_W'(0) - tot1_c;
		sum2_s2 <= tot2_c;
	end

endmodule

FILE: rtl/core/wsac_hex.sv
// ASCII sum of the message hex digits selected by the digit count.
// Depends on wsac_pkg.
module wsac_hex import wsac_pkg::*; (
	input  logic             clk,
	input  logic [MSG_W-1:0] message,
	input  logic [DC_W-1:0]  digit_count,
	output logic [7:0]       asum_s2
);

	logic [MSG_W-1:0] masked_c;
	logic [7:0]       pair_c [NIB_PAIRS];
	logic [7:0]       pair_s1 [NIB_PAIRS];
	logic [7:0]       extra_c;
	logic [7:0]       extra_s1;
	logic [7:0]       tot_c;
	logic [7:0]       asc0, asc1;

	always_comb begin
		for (int i = 0; i < MSG_W / 8; i++) begin
			masked_c[8*i +: 8] = msg_byte(message, i);
		end
		for (int k = 0; k < NIB_PAIRS; k++) begin
			asc0 = (DC_W'(2*k) < digit_count) ? hex_ascii(masked_c[8*k +: 4]) : 8'd0;
			asc1 = (DC_W'(2*k + 1) < digit_count) ? hex_ascii(masked_c[8*k + 4 +: 4]) : 8'd0;
			pair_c[k] = asc0 + asc1;
		end
		// Digits past the message read as '0'.
		if (digit_count > DC_W'(HEX_DIGITS)) begin
			extra_c = 8'(8'(digit_count - DC_W'(HEX_DIGITS)) * ASCII_ZERO);
		end else begin
			extra_c = 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		pair_s1  <= pair_c;
		extra_s1 <= extra_c;
	end

	always_comb begin
		tot_c = extra_s1;
		for (int k = 0; k < NIB_PAIRS; k++) begin
			tot_c = tot_c + pair_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		asum_s2 <= tot_c;
	end

endmodule

FILE: rtl/core/wsac_check.sv
// End-around fold of both sums, then the ASCII digits of the two check bytes.
// Depends on wsac_pkg.
module wsac_check import wsac_pkg::*; (
	input  logic              clk,
	input  logic [SUM1_W-1:0] sum1_s2,
	input  logic [SUM2_W-1:0] sum2_s2,
	input  logic [7:0]        asum_s2,
	output logic [CODE_W-1:0] code_s4
);

	logic [8:0] t1_c, t2_c;
	logic [7:0] f1_c, f2_c;
	logic [7:0] c1_s3, c2_s3, asum_s3;
	logic [SUM1_W-1:0] sum2_wide;
	logic [7:0] fin_c;

	assign sum2_wide = SUM1_W'(sum2_s2);

	// Two fold steps bring any 16-bit value below 256.
	always_comb begin
		t1_c = {1'b0, sum1_s2[7:0]} + {1'b0, sum1_s2[15:8]};
		f1_c = t1_c[7:0] + {7'd0, t1_c[8]};
		t2_c = {1'b0, sum2_wide[7:0]} + {1'b0, sum2_wide[15:8]};
		f2_c = t2_c[7:0] + {7'd0, t2_c[8]};
	end

	always_ff @(posedge clk) begin
		c1_s3   <= f1_c - 8'd1;
		c2_s3   <= f2_c;
		asum_s3 <= asum_s2;
	end

	assign fin_c = asum_s3 + hex_ascii(c2_s3[3:0]) + hex_ascii(c2_s3[7:4])
	             + hex_ascii(c1_s3[3:0]) + hex_ascii(c1_s3[7:4]);

	always_ff @(posedge clk) begin
		code_s4 <= {c1_s3, c2_s3, fin_c};
	end

endmodule

FILE: rtl/core/weighted_sum_ascii_checksum_top.sv
// Weighted-sum ASCII checksum, top level.
// Depends on wsac_pkg, wsac_sum, wsac_hex and wsac_check.
//
// Usage:
//   Drive message and digit_count and raise start for one cycle per item.
//   An item transfers at a rising edge with start high and busy low; busy
//   is always low, so a new item may enter in every cycle.
//   check_code appears with done once the item has passed the pipeline, valid for exactly one
//   cycle while done is high. Results leave in input order.
//   Throughput: 1 item per cycle, set by the four-stage
//   pipeline (products and pair sums, totals, fold, check-byte digit sum).
//   The receiver cannot stall; done is a strobe and check_code is not held.
//   Reset (arst_n low) clears the stage valid bits at once, dropping items in
//   flight; no result is strobed until new items arrive.
module weighted_sum_ascii_checksum_top import wsac_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [MSG_W-1:0]  message,
	input  logic [DC_W-1:0]   digit_count,
	output logic              done,
	output logic [CODE_W-1:0] check_code
);

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic [SUM1_W-1:0] sum1_s2;
	logic [SUM2_W-1:0] sum2_s2;
	logic [7:0]        asum_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	wsac_sum u_sum (
		.clk     (clk),
		.message (message),
		.sum1_s2 (sum1_s2),
		.sum2_s2 (sum2_s2)
	);

	wsac_hex u_hex (
		.clk         (clk),
		.message     (message),
		.digit_count (digit_count),
		.asum_s2     (asum_s2)
	);

	wsac_check u_check (
		.clk     (clk),
		.sum1_s2 (sum1_s2),
		.sum2_s2 (sum2_s2),
		.asum_s2 (asum_s2),
		.code_s4 (check_code)
	);

	assign done = valid_s4;

endmodule
